// ===== rtl/waveform_phase_run_decoder_top_macros.svh =====
// assertion macros used by the waveform phase run decoder rtl
`ifndef WAVEFORM_PHASE_RUN_DECODER_TOP_MACROS_SVH
`define WAVEFORM_PHASE_RUN_DECODER_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define WPRD_CHECK_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define WPRD_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wprd_pkg.sv =====
// types, byte codes and width helpers for the waveform phase run decoder
package wprd_pkg;

    localparam logic [7:0] TOGGLE_BYTE = 8'hFC;
    localparam logic [7:0] END_BYTE    = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] phases;
        logic [8:0] run_length;
        logic [9:0] frame_index;
        logic [4:0] target_level;
        logic [4:0] source_level;
        logic       overflow;
    } t_out_item;

    // run leaving the decode stage, position travels beside it
    typedef struct packed {
        logic [7:0] phases;
        logic [8:0] run_length;
        logic       overflow;
        logic       at_limit;
    } t_run_info;

    function automatic int groups_per_row(input int levels);
        int g;
        g = levels / 4;
        return (g > 0) ? g : 1;
    endfunction

    // bits to hold a group position from zero up to the saturated end
    function automatic int pos_width(input int levels, input int frames);
        int total;
        total = groups_per_row(levels) * levels * frames;
        return $clog2(total + 1);
    endfunction

endpackage

// ===== rtl/wprd_locate.sv =====
// splits a linear group position into frame, target and source level
module wprd_locate #(
    parameter int LEVELS     = 32,
    parameter int MAX_FRAMES = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  wprd_pkg::t_run_info      i_info,
    input  logic [wprd_pkg::pos_width(LEVELS, MAX_FRAMES)-1:0] i_pos,
    output logic                     o_valid,
    input  logic                     i_ready,
    output wprd_pkg::t_out_item      o_item
);
    import wprd_pkg::*;

    localparam int GPR   = groups_per_row(LEVELS);
    localparam int TOTAL = GPR * LEVELS * MAX_FRAMES;
    localparam int ROWS  = LEVELS * MAX_FRAMES;

    localparam int N1  = $clog2(TOTAL);
    localparam int L1  = $clog2(GPR);
    localparam int S1  = N1 + L1;
    localparam int RW  = $clog2(ROWS);
    localparam int L2  = $clog2(LEVELS);
    localparam int S2  = RW + L2;
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int SIW = (GPR > 1) ? $clog2(GPR) : 1;
    localparam int P1W = 2 * N1 + 1;
    localparam int P2W = 2 * RW + 1;

    // ceil(2^S / d): exact floor division for dividends below 2^N
    localparam logic [63:0] M1 = ((64'd1 << S1) + 64'(GPR) - 64'd1) / 64'(GPR);
    localparam logic [63:0] M2 = ((64'd1 << S2) + 64'(LEVELS) - 64'd1) / 64'(LEVELS);

    logic            rdy_out, rdy3, rdy2;

    logic            r_v2;
    t_run_info       r2_info;
    logic [N1-1:0]   r2_pos;
    logic [RW-1:0]   r2_row;

    logic            r_v3;
    t_run_info       r3_info;
    logic [RW-1:0]   r3_row;
    logic [FW-1:0]   r3_frame;
    logic [SIW-1:0]  r3_src;

    logic            r_vo;
    t_out_item       r_out;

    logic [P1W-1:0]  prod1;
    logic [P2W-1:0]  prod2;
    logic [N1-1:0]   src_full;
    logic [RW-1:0]   tgt_full;
    logic [SIW+1:0]  src_level;
    t_out_item       n_out;

    assign rdy_out = !r_vo || i_ready;
    assign rdy3    = !r_v3 || rdy_out;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // row = position / groups per row
    assign prod1 = P1W'(i_pos[N1-1:0]) * P1W'(M1);

    // source group = position - row * groups per row, frame = row / levels
    assign src_full = r2_pos - N1'(N1'(r2_row) * N1'(GPR));
    assign prod2    = P2W'(r2_row) * P2W'(M2);

    // target = row - frame * levels
    assign tgt_full  = r3_row - RW'(RW'(r3_frame) * RW'(LEVELS));
    assign src_level = {r3_src, 2'b00};

    always_comb begin
        n_out.phases       = r3_info.phases;
        n_out.run_length   = r3_info.run_length;
        n_out.overflow     = r3_info.overflow;
        n_out.frame_index  = 10'(r3_frame);
        n_out.target_level = 5'(tgt_full[L2-1:0]);
        n_out.source_level = 5'(src_level);
        if (r3_info.at_limit) begin
            n_out.frame_index  = '0;
            n_out.target_level = '0;
            n_out.source_level = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_out) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r2_info <= i_info;
            r2_pos  <= i_pos[N1-1:0];
            r2_row  <= prod1[S1 +: RW];
        end
        if (rdy3 && r_v2) begin
            r3_info  <= r2_info;
            r3_row   <= r2_row;
            r3_frame <= prod2[S2 +: FW];
            r3_src   <= src_full[SIW-1:0];
        end
        if (rdy_out && r_v3) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_out;

endmodule

// ===== rtl/waveform_phase_run_decoder_top.sv =====
// top level of the waveform phase run decoder
// Takes the bytes of one display-waveform block, one item per clock while
// ready, and emits one run item for every decoded data byte: its four 2-bit
// phases (bits 7:6 for the lowest source level), the number of four-phase
// groups it covers, and where the run starts as frame, target level and first
// source level. Byte 0xFC toggles repeat mode (on at block start); in repeat
// mode each data byte is followed by a count byte giving count+1 groups, a data
// byte on the block_end item gets one group, and 0xFF followed by a count ends
// the block. Once the block has ended, items are taken and dropped until one
// with block_start. The group position saturates at MAX_FRAMES frames and
// flags overflow on every run that reaches past it or starts there. Throughput
// is one input item per clock with no bubbles while the output is not stalled;
// a run passes through four registers in all: the byte decode and position add
// end in one register, and the position split, which divides by the groups per
// row and by LEVELS with constant reciprocal multiplies spread over its stages,
// adds three more. A stalled output backs up through these registers before
// the input stalls.
`include "waveform_phase_run_decoder_top_macros.svh"

module waveform_phase_run_decoder_top #(
    parameter int LEVELS     = 32,
    parameter int MAX_FRAMES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wprd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wprd_pkg::t_out_item o_out_item
);
    import wprd_pkg::*;

    localparam int GPR   = groups_per_row(LEVELS);
    localparam int TOTAL = GPR * LEVELS * MAX_FRAMES;
    localparam int PW    = pos_width(LEVELS, MAX_FRAMES);
    // compare width, wide enough for both the position and a run length
    localparam int CW    = ((PW > 9) ? PW : 9) + 1;
    localparam logic [PW-1:0] TOTAL_P = PW'(TOTAL);

    // decoder state
    logic            r_repeat_on;
    logic            r_pend_valid;
    logic [7:0]      r_pend_phases;
    logic [PW-1:0]   r_pos;
    logic            r_stopped;

    // state as seen by this item, after a block start clears it
    logic            eff_repeat;
    logic            eff_pend_valid;
    logic [7:0]      eff_pend_phases;
    logic [PW-1:0]   eff_pos;
    logic            eff_stopped;

    logic            n_repeat_on;
    logic            n_pend_valid;
    logic [7:0]      n_pend_phases;
    logic [PW-1:0]   n_pos;
    logic            n_stopped;

    logic            in_fire;
    logic            emit;
    logic [7:0]      run_phases;
    logic [8:0]      run_len;
    logic            run_at_limit;
    logic            run_ovf;
    logic [CW-1:0]   room;
    logic [CW-1:0]   pos_sum;

    // decode stage output register
    logic            r_v1;
    t_run_info       r_s1_info;
    logic [PW-1:0]   r_s1_pos;
    logic            loc_ready;
    t_run_info       n_info;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_v1 || loc_ready;

    always_comb begin
        // block start restarts the decoder before this byte is handled
        eff_repeat      = i_in_item.block_start ? 1'b1 : r_repeat_on;
        eff_pend_valid  = i_in_item.block_start ? 1'b0 : r_pend_valid;
        eff_pend_phases = i_in_item.block_start ? 8'd0 : r_pend_phases;
        eff_pos         = i_in_item.block_start ? '0 : r_pos;
        eff_stopped     = i_in_item.block_start ? 1'b0 : r_stopped;

        n_repeat_on   = eff_repeat;
        n_pend_valid  = eff_pend_valid;
        n_pend_phases = eff_pend_phases;
        n_stopped     = eff_stopped;

        emit       = 1'b0;
        run_phases = i_in_item.data_byte;
        run_len    = 9'd1;

        if (!eff_stopped) begin
            if (eff_pend_valid) begin
                // this byte is the count of the pending data byte
                n_pend_valid = 1'b0;
                if (eff_pend_phases == END_BYTE) begin
                    n_stopped = 1'b1;
                end else begin
                    emit       = 1'b1;
                    run_phases = eff_pend_phases;
                    run_len    = {1'b0, i_in_item.data_byte} + 9'd1;
                end
            end else if (i_in_item.data_byte == TOGGLE_BYTE) begin
                n_repeat_on = !eff_repeat;
            end else if (eff_repeat && !i_in_item.block_end) begin
                n_pend_valid  = 1'b1;
                n_pend_phases = i_in_item.data_byte;
            end else begin
                // plain data, or the last byte of the block: one group
                emit = 1'b1;
            end
            if (i_in_item.block_end) begin
                n_stopped    = 1'b1;
                n_pend_valid = 1'b0;
            end
        end

        // saturation: a run past the end parks the position at the end
        run_at_limit = (eff_pos == TOTAL_P);
        room         = CW'(TOTAL_P) - CW'(eff_pos);
        run_ovf      = run_at_limit || (room < CW'(run_len));
        pos_sum      = CW'(eff_pos) + CW'(run_len);
        n_pos        = eff_pos;
        if (emit) begin
            n_pos = run_ovf ? TOTAL_P : pos_sum[PW-1:0];
        end

        n_info.phases     = run_phases;
        n_info.run_length = run_len;
        n_info.overflow   = run_ovf;
        n_info.at_limit   = run_at_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_on   <= 1'b1;
            r_pend_valid  <= 1'b0;
            r_pend_phases <= 8'd0;
            r_pos         <= '0;
            r_stopped     <= 1'b0;
            r_v1          <= 1'b0;
        end else begin
            if (in_fire) begin
                r_repeat_on   <= n_repeat_on;
                r_pend_valid  <= n_pend_valid;
                r_pend_phases <= n_pend_phases;
                r_pos         <= n_pos;
                r_stopped     <= n_stopped;
            end
            // when ready, the held run is either absent or taken downstream
            if (o_in_ready) begin
                r_v1 <= in_fire && emit;
            end
        end
    end

    // run payload and its start position
    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_s1_info <= n_info;
            r_s1_pos  <= eff_pos;
        end
    end

    // position split and output register
    wprd_locate #(
        .LEVELS     (LEVELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .o_ready (loc_ready),
        .i_info  (r_s1_info),
        .i_pos   (r_s1_pos),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // checks on the decode state
    `WPRD_CHECK_NOW(a_pos_in_range, r_pos <= TOTAL_P, "group position past saturation")
    `WPRD_CHECK_NOW(a_no_pend_when_stopped, !(r_pend_valid && r_stopped), "pending byte after end")
    `WPRD_CHECK_NEXT(a_no_run_without_emit, in_fire && !emit, !r_v1, "run queued without emit")
    `WPRD_CHECK_NEXT(a_ovf_parks_pos, in_fire && emit && run_ovf, r_pos == TOTAL_P, "pos not parked")

endmodule

// ===== sim/wprd_run_checker.sv =====
`timescale 1ns / 100ps
// run checker for the waveform phase run decoder: watches both channels, predicts and compares
module wprd_run_checker #(
    parameter int LEVELS     = 32,
    parameter int MAX_FRAMES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  wprd_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  wprd_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_runs_pending
);
    import wprd_pkg::*;

    localparam int unsigned ROW_GROUPS = (LEVELS / 4 > 0) ? LEVELS / 4 : 1;
    localparam int unsigned END_GROUP  = ROW_GROUPS * LEVELS * MAX_FRAMES;

    bit          repeating;
    bit          held_valid;
    logic [7:0]  held_phases;
    int unsigned group_pos;
    bit          block_done;

    t_out_item runs_due[$];
    int        fail_count;
    int        runs_left;

    assign o_fail_count   = fail_count;
    assign o_runs_pending = runs_left;

    function automatic void clear_decoder();
        repeating   = 1'b1;
        held_valid  = 1'b0;
        held_phases = '0;
        group_pos   = 0;
        block_done  = 1'b0;
    endfunction

    // place a run at the current group position, then advance or saturate
    function automatic void predict_run(input logic [7:0] phases, input int unsigned groups);
        t_out_item   run;
        int unsigned row;
        run            = '0;
        run.phases     = phases;
        run.run_length = groups[8:0];
        if (group_pos >= END_GROUP) begin
            group_pos    = END_GROUP;
            run.overflow = 1'b1;
        end else begin
            row              = group_pos / ROW_GROUPS;
            run.source_level = 5'((group_pos % ROW_GROUPS) * 4);
            run.target_level = 5'(row % LEVELS);
            run.frame_index  = 10'(row / LEVELS);
            run.overflow     = (END_GROUP - group_pos) < groups;
        end
        if (run.overflow)
            group_pos = END_GROUP;
        else
            group_pos = group_pos + groups;
        runs_due.insert(runs_due.size(), run);
    endfunction

    function automatic void decode_byte(input t_in_item item);
        if (item.block_start)
            clear_decoder();
        if (block_done)
            return;
        if (held_valid) begin
            // count byte, whatever its value
            held_valid = 1'b0;
            if (held_phases == END_BYTE)
                block_done = 1'b1;
            else
                predict_run(held_phases, int'(item.data_byte) + 1);
        end else if (item.data_byte == TOGGLE_BYTE) begin
            repeating = !repeating;
        end else if (repeating && !item.block_end) begin
            held_valid  = 1'b1;
            held_phases = item.data_byte;
        end else begin
            predict_run(item.data_byte, 1);
        end
        if (item.block_end) begin
            block_done = 1'b1;
            held_valid = 1'b0;
        end
    endfunction

    function automatic void check_run(input t_out_item got);
        t_out_item want;
        if (runs_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected run: ph=%h len=%0d frame=%0d tgt=%0d src=%0d ovf=%b",
                         got.phases, got.run_length, got.frame_index, got.target_level,
                         got.source_level, got.overflow);
            return;
        end
        want = runs_due.pop_front();
        if (got.phases !== want.phases || got.run_length !== want.run_length ||
            got.frame_index !== want.frame_index || got.target_level !== want.target_level ||
            got.source_level !== want.source_level || got.overflow !== want.overflow) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("run mismatch at %0t", $realtime);
                $display("  expected ph=%h len=%0d frame=%0d tgt=%0d src=%0d ovf=%b",
                         want.phases, want.run_length, want.frame_index, want.target_level,
                         want.source_level, want.overflow);
                $display("  actual   ph=%h len=%0d frame=%0d tgt=%0d src=%0d ovf=%b",
                         got.phases, got.run_length, got.frame_index, got.target_level,
                         got.source_level, got.overflow);
            end
        end
    endfunction

    initial begin
        fail_count = 0;
        runs_left  = 0;
        clear_decoder();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            runs_due.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_run(i_out_item);
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_item);
        end
        runs_left = runs_due.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the waveform phase run decoder: stimulus, idling, watchdog and verdict
module tb;
    import wprd_pkg::*;

    localparam int LEVELS       = 32;
    localparam int MAX_FRAMES   = 1024;
    localparam int RANDOM_ITEMS = 1550;  // total input items before the stimulus stops
    localparam int QUIET_ITEMS  = 150;   // closing stretch with no idling
    localparam int LONG_HOLD    = 400;   // receiver hold-off, long enough to back up the input
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving before giving up
    localparam int TAIL_CYCLES  = 20;    // extra cycles after the drain before the verdict

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int fail_count;
    int runs_pending;
    int runs_taken;
    int still_cycles;
    int items_sent;
    bit quiet;        // no idling on either side
    bit tx_idle_on;   // sender idling enabled for the current block

    waveform_phase_run_decoder_top #(
        .LEVELS     (LEVELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    wprd_run_checker #(
        .LEVELS     (LEVELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_runs_pending (runs_pending)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // count results taken, used by the receiver to time its long hold-off
    always @(posedge clk) begin
        if (!rst_n)
            runs_taken <= 0;
        else if (out_valid && out_ready)
            runs_taken <= runs_taken + 1;
    end

    // watchdog: nothing moving on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            still_cycles <= 0;
        end else begin
            still_cycles <= still_cycles + 1;
            if (still_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side: random stall bursts, calm stretches, and one long hold-off
    initial begin : result_sink
        int  busy_pct;
        int  calm_left;
        int  gap_left;
        int  hold_left;
        bit  held_long;
        busy_pct  = 0;
        calm_left = 0;
        gap_left  = 0;
        hold_left = 0;
        held_long = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            // at the start of each calm stretch pick how busy the receiver is, zero included
            if (calm_left == 0) begin
                calm_left = 100;
                case ($urandom_range(0, 2))
                    0: busy_pct = 0;
                    1: busy_pct = 15;
                    default: busy_pct = 40;
                endcase
            end
            calm_left--;
            if (!held_long && runs_taken >= 150) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(1, 100) <= busy_pct) begin
                gap_left = $urandom_range(0, 5);  // burst length drawn at random
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // offer one byte, maybe after an idle burst, and hold it until taken;
    // entered and left at a falling edge
    task automatic send(input logic [7:0] b, input logic first, input logic last);
        int gap;
        if (!quiet && tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid              <= 1'b1;
        in_item.data_byte     <= b;
        in_item.block_start   <= first;
        in_item.block_end     <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // sender goes quiet until every predicted run has come out
    task automatic wait_for_runs();
        if (runs_pending != 0) begin
            in_valid <= 1'b0;
            while (runs_pending != 0)
                @(negedge clk);
        end
    endtask

    // phase byte that is neither a mode toggle nor an end marker
    function automatic logic [7:0] phase_pick();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == TOGGLE_BYTE || b == END_BYTE);
        return b;
    endfunction

    initial begin : stimulus
        logic [7:0] b;
        logic [7:0] c;
        bit         rep;
        bit         first;
        bit         paused_mid;
        int         n;
        int         k;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        quiet       = 1'b0;
        tx_idle_on  = 1'b1;
        items_sent  = 0;
        paused_mid  = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: runs of one and 256 groups, extremes of phases
        send(8'h00, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        send(8'hE4, 1'b0, 1'b0);
        send(8'hFF, 1'b0, 1'b0);
        // count byte equal to the toggle code is still a count
        send(8'h1B, 1'b0, 1'b0);
        send(TOGGLE_BYTE, 1'b0, 1'b0);
        send(8'h55, 1'b0, 1'b0);
        send(8'h7F, 1'b0, 1'b0);
        // repeat off: end code is plain data of one group
        send(TOGGLE_BYTE, 1'b0, 1'b0);
        send(END_BYTE, 1'b0, 1'b0);
        send(8'h01, 1'b0, 1'b0);
        send(TOGGLE_BYTE, 1'b0, 1'b0);
        // data on the last byte in repeat mode gets one group
        send(8'h27, 1'b0, 1'b1);
        // after the block has ended, bytes are dropped
        send(8'h12, 1'b0, 1'b0);
        send(END_BYTE, 1'b0, 1'b0);
        // end pair stops the block, nothing comes out
        send(END_BYTE, 1'b1, 1'b0);
        send(8'h03, 1'b0, 1'b0);
        send(8'h44, 1'b0, 1'b0);
        // end code on a start-and-last byte is a single group of data
        send(END_BYTE, 1'b1, 1'b1);
        // count byte arriving on the last byte
        send(8'hAA, 1'b1, 1'b0);
        send(TOGGLE_BYTE, 1'b0, 1'b1);
        // repeat off then data on the last byte
        send(TOGGLE_BYTE, 1'b1, 1'b0);
        send(8'h3C, 1'b0, 1'b1);
        // block start while a data byte waits for its count drops it
        send(8'h81, 1'b1, 1'b0);
        send(8'h10, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b0);
        // toggle on a start-and-last byte
        send(TOGGLE_BYTE, 1'b1, 1'b1);
        wait_for_runs();

        // random blocks, mostly well formed
        while (items_sent < RANDOM_ITEMS) begin
            if (!paused_mid && items_sent >= RANDOM_ITEMS / 2) begin
                paused_mid = 1'b1;
                wait_for_runs();
            end
            quiet      = items_sent >= RANDOM_ITEMS - QUIET_ITEMS;
            tx_idle_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) == 0) begin
                // noise: any byte with any flags
                n = $urandom_range(1, 12);
                for (k = 0; k < n; k++) begin
                    b = 8'($urandom_range(0, 255));
                    send(b, $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
                end
            end else begin
                rep   = 1'b1;
                first = 1'b1;
                n     = $urandom_range(1, 30);
                for (k = 0; k < n; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send(TOGGLE_BYTE, first, 1'b0);
                        rep = !rep;
                    end else if (rep) begin
                        c = 8'($urandom_range(0, 255));
                        send(phase_pick(), first, 1'b0);
                        send(c, 1'b0, 1'b0);
                    end else begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == TOGGLE_BYTE);
                        send(b, first, 1'b0);
                    end
                    first = 1'b0;
                end
                // close the block one of several ways
                case ($urandom_range(0, 3))
                    0: begin
                        c = 8'($urandom_range(0, 255));
                        send(END_BYTE, first, 1'b0);
                        send(c, 1'b0, 1'b0);
                        // trailing bytes that the block drops
                        repeat ($urandom_range(0, 3)) begin
                            b = 8'($urandom_range(0, 255));
                            send(b, 1'b0, 1'($urandom_range(0, 1)));
                        end
                    end
                    1: begin
                        send(phase_pick(), first, 1'b0);
                        c = 8'($urandom_range(0, 255));
                        send(c, 1'b0, 1'b1);
                    end
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        send(b, first, 1'b1);
                    end
                endcase
            end
        end
        in_valid <= 1'b0;

        // drain, then allow for anything still in the pipeline
        while (runs_pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wprd_pkg.sv
rtl/wprd_locate.sv
rtl/waveform_phase_run_decoder_top.sv
sim/wprd_run_checker.sv
sim/tb.sv
